/* design/xtea_ofb_pkg.sv */
// ----------------------------------------------------------------------------
// XTEA OFB package
// Shared constants, types and the XTEA mixing function.
// ----------------------------------------------------------------------------
package xtea_ofb_pkg;

    localparam int unsigned CFG_DATA_W = 64;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned KEY_WORDS  = 4;
    localparam int unsigned KEY_AW     = $clog2(KEY_WORDS);
    localparam int unsigned ROUNDS     = 32;
    localparam int unsigned ROUND_W    = $clog2(ROUNDS);

    typedef logic [CFG_IDX_W-1:0]  cfg_index_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;
    typedef logic [31:0]           word_t;
    typedef logic [63:0]           block_t;
    typedef logic [7:0]            byte_t;
    typedef logic [3:0]            pos_t;

    // register indexes
    localparam cfg_index_t CFG_KEY_WORD0      = 3'd0;
    localparam cfg_index_t CFG_KEY_WORD1      = 3'd1;
    localparam cfg_index_t CFG_KEY_WORD2      = 3'd2;
    localparam cfg_index_t CFG_KEY_WORD3      = 3'd3;
    localparam cfg_index_t CFG_INITIAL_VECTOR = 3'd4;

    // input function codes
    localparam logic FUNC_DATA    = 1'b0;
    localparam logic FUNC_RESTART = 1'b1;

    localparam word_t  XTEA_DELTA = 32'h9E37_79B9;
    localparam block_t IV_RESET   = 64'h0706_0504_0302_0100;
    localparam pos_t   POS_USED   = 4'd8;

    // ((v << 4) ^ (v >> 5)) + v
    function automatic word_t xtea_mix(input word_t v);
        xtea_mix = ((v << 4) ^ (v >> 5)) + v;
    endfunction

endpackage

/* design/xtea_ofb_if.sv */
// ----------------------------------------------------------------------------
// XTEA OFB stream interfaces
// Valid/ready channels for input items and result bytes.
// ----------------------------------------------------------------------------
interface xtea_ofb_item_if
    import xtea_ofb_pkg::*;
;
    logic  valid;
    logic  ready;
    logic  func;
    byte_t in_byte;

    modport source (output valid, output func, output in_byte, input ready);
    modport sink   (input valid, input func, input in_byte, output ready);
endinterface

interface xtea_ofb_result_if
    import xtea_ofb_pkg::*;
;
    logic  valid;
    logic  ready;
    byte_t out_byte;

    modport source (output valid, output out_byte, input ready);
    modport sink   (input valid, input out_byte, output ready);
endinterface

/* design/xtea_ofb_ram.sv */
// ----------------------------------------------------------------------------
// XTEA OFB generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module xtea_ofb_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/xtea_ofb_byte_stream_cipher.sv */
// ----------------------------------------------------------------------------
// XTEA OFB byte stream cipher
// XTEA (64-bit block, 128-bit key) in output feedback mode, one byte a beat.
// ----------------------------------------------------------------------------
// Each data beat (func = 0) returns in_byte XOR the next byte of the current
// 64-bit keystream block, taken little-endian from byte 0 up. A byte that
// falls in a block not yet used up is XORed straight into the result
// register, and a new item is taken each cycle while the result register
// drains. When the block is used up, the next data beat first encrypts the
// block in place: the 32 XTEA rounds, one full XTEA cycle (two half-rounds)
// per clock, then the emit state, which loads that beat's byte into the
// result register once it is free; only then is the next beat taken.
// The refill is bound by the round datapath and by the key memory,
// which is read once per half-round through two copies of the 4 x 32 key
// RAM, fetched in the cycle before use. A restart beat (func = 1) reloads the
// block from initial_vector, produces no result and makes the next data beat
// trigger an encryption. Configuration (key words 0..3, initial_vector at
// index 4; higher indexes ignored) is to be written by the user only while
// the block is idle, which the block does not enforce; key writes apply at
// the next encryption, an IV write at the next restart. Unwritten key RAM
// entries read as zero through per-entry valid bits; no clearing after reset.
// ----------------------------------------------------------------------------
module xtea_ofb_byte_stream_cipher
    import xtea_ofb_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    xtea_ofb_item_if.sink            item,
    xtea_ofb_result_if.source        result,
    input  logic                     cfg_we,
    input  cfg_index_t               cfg_index,
    input  cfg_data_t                cfg_data
);

    // control states
    localparam logic [1:0] ST_IDLE = 2'd0;  // taking beats
    localparam logic [1:0] ST_RUN  = 2'd1;  // encrypting the block
    localparam logic [1:0] ST_EMIT = 2'd2;  // first byte of the new block

    logic [1:0]           state_reg, state_next;
    pos_t                 pos_reg, pos_next;
    block_t               block_reg, block_next;
    block_t               iv_reg, iv_next;
    logic [ROUND_W-1:0]   round_reg, round_next;
    logic [KEY_WORDS-1:0] key_valid_reg, key_valid_next;
    logic                 kva_reg, kva_next;
    logic                 kvb_reg, kvb_next;
    logic                 ov_reg, ov_next;

    // payload registers
    word_t                sum_reg, sum_next;
    byte_t                pend_reg, pend_next;
    byte_t                obyte_reg, obyte_next;

    // key memory access
    logic                 key_we;
    logic [KEY_AW-1:0]    addr_a, addr_b;
    word_t                rdata_a, rdata_b;
    word_t                sum_fetch, sum_fetch_b;

    // round datapath
    word_t                key_a, key_b;
    word_t                y_cur, z_cur, y_new, z_new;
    word_t                sum_step, ka, kb;

    logic                 out_free;
    logic                 accept;
    byte_t                ks_byte;

    assign key_we = cfg_we && (cfg_index[CFG_IDX_W-1] == 1'b0);

    // Two copies of the key store, one per half-round port.
    xtea_ofb_ram #(
        .WIDTH (32),
        .DEPTH (KEY_WORDS)
    ) u_key_ram_a (
        .clk   (clk),
        .we    (key_we),
        .waddr (cfg_index[KEY_AW-1:0]),
        .wdata (cfg_data[31:0]),
        .raddr (addr_a),
        .rdata (rdata_a)
    );

    xtea_ofb_ram #(
        .WIDTH (32),
        .DEPTH (KEY_WORDS)
    ) u_key_ram_b (
        .clk   (clk),
        .we    (key_we),
        .waddr (cfg_index[KEY_AW-1:0]),
        .wdata (cfg_data[31:0]),
        .raddr (addr_b),
        .rdata (rdata_b)
    );

    // Fetch for the next cycle: outside RUN the next round is round 0 (sum 0),
    // inside RUN it is the one after the current round.
    assign sum_fetch   = (state_reg == ST_RUN) ? (sum_reg + XTEA_DELTA) : '0;
    assign sum_fetch_b = sum_fetch + XTEA_DELTA;
    assign addr_a      = sum_fetch[KEY_AW-1:0];
    assign addr_b      = sum_fetch_b[11+KEY_AW-1:11];

    // Unwritten key words read as zero.
    assign key_a = kva_reg ? rdata_a : '0;
    assign key_b = kvb_reg ? rdata_b : '0;

    // One XTEA cycle: two dependent half-rounds.
    assign y_cur    = block_reg[31:0];
    assign z_cur    = block_reg[63:32];
    assign ka       = sum_reg + key_a;
    assign y_new    = y_cur + (xtea_mix(z_cur) ^ ka);
    assign sum_step = sum_reg + XTEA_DELTA;
    assign kb       = sum_step + key_b;
    assign z_new    = z_cur + (xtea_mix(y_new) ^ kb);

    assign out_free   = !ov_reg || result.ready;
    assign item.ready = (state_reg == ST_IDLE) && out_free;
    assign accept     = item.valid && item.ready;
    assign ks_byte    = block_reg[{pos_reg[2:0], 3'b000} +: 8];

    assign result.valid    = ov_reg;
    assign result.out_byte = obyte_reg;

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        block_next     = block_reg;
        iv_next        = iv_reg;
        round_next     = round_reg;
        key_valid_next = key_valid_reg;
        sum_next       = sum_reg;
        pend_next      = pend_reg;
        obyte_next     = obyte_reg;
        kva_next       = key_valid_reg[addr_a];
        kvb_next       = key_valid_reg[addr_b];
        ov_next        = ov_reg && !result.ready;

        // configuration
        if (key_we)
        begin
            key_valid_next[cfg_index[KEY_AW-1:0]] = 1'b1;
        end
        if (cfg_we && (cfg_index == CFG_INITIAL_VECTOR))
        begin
            iv_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.func == FUNC_RESTART)
                    begin
                        block_next = iv_reg;
                        pos_next   = POS_USED;
                    end
                    else if (pos_reg[3])
                    begin
                        // block used up (positions 9..15 act as 8)
                        pend_next  = item.in_byte;
                        sum_next   = '0;
                        round_next = '0;
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        ov_next    = 1'b1;
                        obyte_next = item.in_byte ^ ks_byte;
                        pos_next   = pos_reg + 4'd1;
                    end
                end
            end
            ST_RUN:
            begin
                block_next = {z_new, y_new};
                sum_next   = sum_step;
                round_next = round_reg + 1'b1;
                if (round_reg == ROUND_W'(ROUNDS - 1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    obyte_next = pend_reg ^ block_reg[7:0];
                    pos_next   = 4'd1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= POS_USED;
            block_reg     <= IV_RESET;
            iv_reg        <= IV_RESET;
            round_reg     <= '0;
            key_valid_reg <= '0;
            kva_reg       <= 1'b0;
            kvb_reg       <= 1'b0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            block_reg     <= block_next;
            iv_reg        <= iv_next;
            round_reg     <= round_next;
            key_valid_reg <= key_valid_next;
            kva_reg       <= kva_next;
            kvb_reg       <= kvb_next;
            ov_reg        <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg   <= sum_next;
        pend_reg  <= pend_next;
        obyte_reg <= obyte_next;
    end

endmodule

/* design/xtea_ofb_checker.sv */
// ----------------------------------------------------------------------------
// XTEA OFB port checker
// Port-level assertions, bound to the cipher top level.
// ----------------------------------------------------------------------------
module xtea_ofb_checker
    import xtea_ofb_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  item_valid,
    input logic  item_ready,
    input logic  item_func,
    input logic  result_valid,
    input logic  result_ready,
    input byte_t result_byte
);

    // a stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_byte))
        else $error("result beat changed while stalled");

    // input is only taken when the result register can accept a byte
    a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
        item_ready |-> (!result_valid || result_ready))
        else $error("item ready with result register full");

    // a restart beat produces no result
    a_restart_silent: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item_func == FUNC_RESTART)
            |=> !result_valid)
        else $error("result after restart beat");

    // a data beat is followed by a result or by a busy period
    a_data_answer: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item_func == FUNC_DATA)
            |=> result_valid || !item_ready)
        else $error("data beat neither answered nor started a refill");

endmodule

bind xtea_ofb_byte_stream_cipher xtea_ofb_checker u_xtea_ofb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_func    (item.func),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_byte  (result.out_byte)
);

/* tb/xtea_ofb_byte_stream_cipher_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XTEA OFB byte stream cipher testbench
// Drives data and restart beats with random gaps and result back-pressure,
// predicts every output byte from its own XTEA keystream model and checks
// the results in order. Key and IV registers are changed between phases,
// only while the cipher is idle.
// ----------------------------------------------------------------------------
module xtea_ofb_byte_stream_cipher_tb
    import xtea_ofb_pkg::*;
;

    // Keystream tracker: mirrors the key/IV registers and the keystream
    // block with its byte position, and holds the bytes still to come out.
    class ofb_keystream_tracker;
        word_t       key_reg [KEY_WORDS];
        block_t      iv_reg;
        block_t      ks_block;
        pos_t        ks_pos;
        byte_t       expected_bytes [$];
        int unsigned mismatches;

        function new();
            foreach (key_reg[i])
                key_reg[i] = '0;
            iv_reg      = IV_RESET;
            ks_block    = IV_RESET;
            ks_pos      = POS_USED;
            mismatches  = 0;
        endfunction

        function void write_reg(cfg_index_t idx, cfg_data_t data);
            case (idx)
                CFG_KEY_WORD0:      key_reg[0] = data[31:0];
                CFG_KEY_WORD1:      key_reg[1] = data[31:0];
                CFG_KEY_WORD2:      key_reg[2] = data[31:0];
                CFG_KEY_WORD3:      key_reg[3] = data[31:0];
                CFG_INITIAL_VECTOR: iv_reg     = data;
                default:            ;
            endcase
        endfunction

        // Full XTEA encryption (ROUNDS loop passes), subkeys picked from the running sum
        function block_t encrypt_block(block_t blk);
            word_t y;
            word_t z;
            word_t sum;
            word_t ka;
            word_t kb;
            y   = blk[31:0];
            z   = blk[63:32];
            sum = '0;
            for (int r = 0; r < ROUNDS; r++)
            begin
                ka  = sum + key_reg[sum[1:0]];
                y   = y + ((((z << 4) ^ (z >> 5)) + z) ^ ka);
                sum = sum + XTEA_DELTA;
                kb  = sum + key_reg[sum[12:11]];
                z   = z + ((((y << 4) ^ (y >> 5)) + y) ^ kb);
            end
            return {z, y};
        endfunction

        // Called for every accepted input beat
        function void take_item(logic func, byte_t data);
            if (func == FUNC_RESTART)
            begin
                ks_block = iv_reg;
                ks_pos   = POS_USED;
                return;
            end
            if (ks_pos >= POS_USED)
            begin
                ks_block = encrypt_block(ks_block);
                ks_pos   = '0;
            end
            expected_bytes.push_back(data ^ byte_t'(ks_block >> {ks_pos, 3'b000}));
            ks_pos = ks_pos + 1'b1;
        endfunction

        // Called for every accepted result beat
        function void check_byte(byte_t got);
            byte_t want;
            if (expected_bytes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result byte %02h", $realtime, got);
                return;
            end
            want = expected_bytes.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: out_byte mismatch: expected %02h, got %02h",
                             $realtime, want, got);
            end
        endfunction

        function int unsigned pending();
            return expected_bytes.size();
        endfunction
    endclass

    localparam int unsigned SETTLE_CYCLES = 40;   // one refill plus margin

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    cfg_index_t cfg_index;
    cfg_data_t  cfg_data;

    xtea_ofb_item_if   item_if ();
    xtea_ofb_result_if result_if ();

    ofb_keystream_tracker tracker;

    bit          idle_on;      // random gaps / stalls enabled
    int unsigned stall_left;

    xtea_ofb_byte_stream_cipher i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_if),
        .result    (result_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 8 ns clock
    initial
        clk = 1'b0;
    always #4 clk = ~clk;

    // Result side: check each accepted beat, then pick ready for the next
    // cycle. Stalls come in bursts, started only while idling is on.
    always @(posedge clk)
    begin
        if (rst_n && result_if.valid && result_if.ready)
            tracker.check_byte(result_if.out_byte);
        if (!rst_n)
            result_if.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            result_if.ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 13) - 1;
            result_if.ready <= 1'b0;
        end
        else
            result_if.ready <= 1'b1;
    end

    // Send one input beat; returns in the time step of the accepting edge.
    // An optional idle gap of random length precedes the beat.
    task automatic send_item(input logic func, input byte_t data);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 13);
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_if.valid   <= 1'b1;
        item_if.func    <= func;
        item_if.in_byte <= data;
        do
            @(posedge clk);
        while (!item_if.ready);
        tracker.take_item(func, data);
    endtask

    // One register write; the caller lowers cfg_we after the last one
    task automatic cfg_write(input cfg_index_t idx, input cfg_data_t data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        tracker.write_reg(idx, data);
        @(posedge clk);
    endtask

    // Write all five registers plus one unused index. Key words carry junk
    // in the upper half of the data bus, which must be dropped.
    task automatic program_regs(input word_t k0, input word_t k1, input word_t k2,
                                input word_t k3, input block_t iv);
        cfg_write(CFG_KEY_WORD0, {$urandom, k0});
        cfg_write(CFG_KEY_WORD1, {$urandom, k1});
        cfg_write(CFG_KEY_WORD2, {$urandom, k2});
        cfg_write(CFG_KEY_WORD3, {$urandom, k3});
        cfg_write(cfg_index_t'($urandom_range(CFG_INITIAL_VECTOR + 1, 2**CFG_IDX_W - 1)),
                  {$urandom, $urandom});
        cfg_write(CFG_INITIAL_VECTOR, iv);
        cfg_we <= 1'b0;
    endtask

    // Wait until every expected byte has come out, then wait a further
    // SETTLE_CYCLES as a margin.
    task automatic settle();
        item_if.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly data beats, about one restart in ten
    task automatic run_random(input int unsigned count);
        for (int unsigned n = 0; n < count; n++)
            send_item(($urandom_range(0, 9) == 0) ? FUNC_RESTART : FUNC_DATA,
                      byte_t'($urandom));
    endtask

    initial
    begin
        tracker    = new();
        idle_on    = 1'b0;

        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= CFG_KEY_WORD0;
        cfg_data           <= '0;
        item_if.valid      <= 1'b0;
        item_if.func       <= FUNC_DATA;
        item_if.in_byte    <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_on = 1'b1;

        // Directed part on reset registers: zero key, default IV.
        // First data beat after reset must refill from the reset block.
        send_item(FUNC_DATA, 8'h00);
        send_item(FUNC_DATA, 8'hFF);
        send_item(FUNC_DATA, 8'h01);
        send_item(FUNC_DATA, 8'h80);
        send_item(FUNC_DATA, 8'h7F);
        send_item(FUNC_DATA, 8'hFE);
        send_item(FUNC_DATA, 8'h55);
        send_item(FUNC_DATA, 8'hAA);
        // block used up: the ninth byte chains into the next encryption
        send_item(FUNC_DATA, 8'h00);
        send_item(FUNC_DATA, 8'hFF);
        // restart ignores in_byte; two in a row behave as one
        send_item(FUNC_RESTART, 8'hFF);
        send_item(FUNC_RESTART, 8'h00);
        send_item(FUNC_DATA, 8'h00);
        send_item(FUNC_DATA, 8'hFF);
        send_item(FUNC_DATA, 8'h3C);
        // restart in the middle of a block
        send_item(FUNC_RESTART, 8'h5A);
        send_item(FUNC_DATA, 8'hC3);
        send_item(FUNC_DATA, 8'h96);
        settle();

        // All-zero key and IV; no restart first, so the old block continues
        program_regs('0, '0, '0, '0, '0);
        run_random(55);
        settle();

        // All-ones key and IV
        program_regs('1, '1, '1, '1, '1);
        send_item(FUNC_RESTART, byte_t'($urandom));
        run_random(55);
        settle();

        // Random settings
        for (int p = 0; p < 4; p++)
        begin
            program_regs($urandom, $urandom, $urandom, $urandom, {$urandom, $urandom});
            if ($urandom_range(0, 1) == 1)
                send_item(FUNC_RESTART, byte_t'($urandom));
            run_random(55);
            settle();
        end

        // Last phase at full rate on both sides
        idle_on = 1'b0;
        program_regs($urandom, $urandom, $urandom, $urandom, {$urandom, $urandom});
        send_item(FUNC_RESTART, byte_t'($urandom));
        run_random(60);
        settle();

        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("xtea_ofb_byte_stream_cipher_tb: done, clean");
        else
            $display("xtea_ofb_byte_stream_cipher_tb: done, errors");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #2_000_000;
        $display("xtea_ofb_byte_stream_cipher_tb: done, errors");
        $finish;
    end

endmodule
